// File: rtl/xfd_pkg.sv
// Shared types, constants and helpers for the XOR float stream decoder.
`default_nettype none

package xfd_pkg;

   localparam int VALUE_W = 32;
   localparam int CNT_W = 5;
   localparam int IW_W = 3;
   localparam int TIDX_W = 4;
   localparam int REM_W = 6;
   localparam int ENT_W = 5;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_DATA_W = 8;

   localparam logic [REM_W-1:0] COUNT_FIELD_BITS = 6'd4;
   localparam logic [REM_W-1:0] ENTRY_FIELD_BITS = 6'd5;
   localparam logic [REM_W-1:0] VALUE_BITS = 6'd32;
   localparam logic [ENT_W-1:0] FULL_TABLE_COUNT = 5'd16;

   localparam logic [VALUE_W-1:0] TERMINATOR_RESET = 32'h7FC0_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_PREV = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERMINATOR = 1'b1;

   typedef struct packed {
      logic en;
      logic sel_trail;
      logic [TIDX_W-1:0] idx;
      logic [CNT_W-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic [TIDX_W-1:0] lead_idx;
      logic [TIDX_W-1:0] trail_idx;
   } tbl_rd_type;

   typedef struct packed {
      logic valid;
      logic [VALUE_W-1:0] value;
      logic last;
   } res_type;

   // Index width for a table of n entries: ceil(log2(n)), at most four bits.
   function automatic logic [IW_W-1:0] width_for(input logic [ENT_W-1:0] n);
      logic [IW_W-1:0] w;
      if (n <= 5'd1) begin
         w = 3'd0;
      end else if (n <= 5'd2) begin
         w = 3'd1;
      end else if (n <= 5'd4) begin
         w = 3'd2;
      end else if (n <= 5'd8) begin
         w = 3'd3;
      end else begin
         w = 3'd4;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/xfd_tables.sv
// Leading-zero and trailing-zero position tables with one shared write port and one read port each.
`default_nettype none

module xfd_tables #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  xfd_pkg::tbl_wr_type  wr,
   input  xfd_pkg::tbl_rd_type  rd,
   output logic [4:0]           lead_data,
   output logic [4:0]           trail_data
);
   import xfd_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [TIDX_W:0] DEPTH_V = (TIDX_W + 1)'(TABLE_DEPTH);

   logic [CNT_W-1:0] lead_ff [TABLE_DEPTH];
   logic [CNT_W-1:0] lead_in [TABLE_DEPTH];
   logic [CNT_W-1:0] trail_ff [TABLE_DEPTH];
   logic [CNT_W-1:0] trail_in [TABLE_DEPTH];
   logic             wr_ok;
   logic             lead_ok;
   logic             trail_ok;

   assign wr_ok = {1'b0, wr.idx} < DEPTH_V;
   assign lead_ok = {1'b0, rd.lead_idx} < DEPTH_V;
   assign trail_ok = {1'b0, rd.trail_idx} < DEPTH_V;

   always_comb begin
      lead_in = lead_ff;
      trail_in = trail_ff;
      if (wr.en && wr_ok) begin
         if (wr.sel_trail) begin
            trail_in[wr.idx[AW-1:0]] = wr.data;
         end else begin
            lead_in[wr.idx[AW-1:0]] = wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            lead_ff[i] <= '0;
            trail_ff[i] <= '0;
         end
      end else begin
         lead_ff <= lead_in;
         trail_ff <= trail_in;
      end
   end

   assign lead_data = lead_ok ? lead_ff[rd.lead_idx[AW-1:0]] : '0;
   assign trail_data = trail_ok ? trail_ff[rd.trail_idx[AW-1:0]] : '0;

endmodule

`default_nettype wire

// File: rtl/xfd_core.sv
// Per-bit decode state machine: header, table reload, value codes, index bits and center bits.
`default_nettype none

module xfd_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           accept,
   input  wire                           bit_i,
   input  wire                           start_i,
   input  wire                           prev_load,
   input  wire  [xfd_pkg::VALUE_W-1:0]   prev_load_val,
   input  wire  [xfd_pkg::VALUE_W-1:0]   terminator,
   input  wire  [xfd_pkg::CNT_W-1:0]     lead_data,
   input  wire  [xfd_pkg::CNT_W-1:0]     trail_data,
   output xfd_pkg::tbl_rd_type           rd,
   output xfd_pkg::tbl_wr_type           wr,
   output xfd_pkg::res_type              res
);
   import xfd_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_UPDATE,
      PH_LCOUNT,
      PH_LENTRY,
      PH_TCOUNT,
      PH_TENTRY,
      PH_CODE0,
      PH_CODE1,
      PH_INDEX,
      PH_CENTER
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               eq_ff, eq_in;
   logic [CNT_W-1:0]   lz_ff, lz_in;
   logic [CNT_W-1:0]   tz_ff, tz_in;
   logic [IW_W-1:0]    liw_ff, liw_in;
   logic [IW_W-1:0]    tiw_ff, tiw_in;
   logic [VALUE_W-1:0] shift_ff, shift_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ENT_W-1:0]   erem_ff, erem_in;
   logic [TIDX_W-1:0]  eidx_ff, eidx_in;
   logic [VALUE_W-1:0] prev_ff, prev_in;

   logic [VALUE_W-1:0] shift_nx;
   logic [REM_W-1:0]   rem_nx;
   logic [ENT_W-1:0]   erem_nx;
   logic [ENT_W-1:0]   tbl_n;
   logic [REM_W-1:0]   idx_w;
   logic [REM_W-1:0]   csum;
   logic [7:0]         idx_vec;
   logic [7:0]         lead_sh;
   logic               emit_req;
   logic               center_req;
   logic               load_req;
   logic [VALUE_W-1:0] emit_val;
   logic [CNT_W-1:0]   c_lz;
   logic [CNT_W-1:0]   c_tz;

   assign shift_nx = {shift_ff[VALUE_W-2:0], bit_i};
   assign rem_nx = (rem_ff != '0) ? rem_ff - 1'b1 : '0;
   assign erem_nx = (erem_ff != '0) ? erem_ff - 1'b1 : '0;
   assign tbl_n = (shift_nx[3:0] == 4'd0) ? FULL_TABLE_COUNT : {1'b0, shift_nx[3:0]};
   assign idx_w = {3'b000, liw_ff} + {3'b000, tiw_ff};

   // Index field: lead index in the high bits, trail index in the low tiw bits.
   assign idx_vec = (phase_ff == PH_INDEX) ? shift_nx[7:0] : 8'd0;
   assign lead_sh = idx_vec >> tiw_ff;
   assign rd.lead_idx = lead_sh[TIDX_W-1:0];
   assign rd.trail_idx = idx_vec[TIDX_W-1:0] & ~(4'hf << tiw_ff);

   always_comb begin
      phase_in = phase_ff;
      eq_in = eq_ff;
      lz_in = lz_ff;
      tz_in = tz_ff;
      liw_in = liw_ff;
      tiw_in = tiw_ff;
      shift_in = shift_ff;
      rem_in = rem_ff;
      erem_in = erem_ff;
      eidx_in = eidx_ff;
      prev_in = prev_ff;
      wr = '0;
      res = '0;
      emit_req = 1'b0;
      center_req = 1'b0;
      load_req = 1'b0;
      emit_val = prev_ff;
      c_lz = lz_ff;
      c_tz = tz_ff;
      csum = '0;

      if (accept) begin
         if (start_i) begin
            eq_in = bit_i;
            phase_in = PH_UPDATE;
         end else begin
            unique case (phase_ff) inside
               PH_IDLE: begin
               end
               PH_UPDATE: begin
                  if (bit_i) begin
                     shift_in = '0;
                     rem_in = COUNT_FIELD_BITS;
                     phase_in = PH_LCOUNT;
                  end else begin
                     phase_in = PH_CODE0;
                  end
               end
               PH_CODE0: begin
                  if (bit_i) begin
                     if (eq_ff) begin
                        emit_req = 1'b1;
                     end else begin
                        center_req = 1'b1;
                     end
                  end else begin
                     phase_in = PH_CODE1;
                  end
               end
               PH_CODE1: begin
                  if (!bit_i) begin
                     if (idx_w == '0) begin
                        load_req = 1'b1;
                     end else begin
                        shift_in = '0;
                        rem_in = idx_w;
                        phase_in = PH_INDEX;
                     end
                  end else if (eq_ff) begin
                     center_req = 1'b1;
                  end else begin
                     emit_req = 1'b1;
                  end
               end
               PH_LCOUNT, PH_LENTRY, PH_TCOUNT, PH_TENTRY, PH_INDEX, PH_CENTER: begin
                  shift_in = shift_nx;
                  rem_in = rem_nx;
                  if (rem_nx == '0) begin
                     unique case (phase_ff) inside
                        PH_LCOUNT, PH_TCOUNT: begin
                           if (phase_ff == PH_LCOUNT) begin
                              liw_in = width_for(tbl_n);
                              phase_in = PH_LENTRY;
                           end else begin
                              tiw_in = width_for(tbl_n);
                              phase_in = PH_TENTRY;
                           end
                           erem_in = tbl_n;
                           eidx_in = '0;
                           shift_in = '0;
                           rem_in = ENTRY_FIELD_BITS;
                        end
                        PH_LENTRY, PH_TENTRY: begin
                           wr.en = 1'b1;
                           wr.sel_trail = (phase_ff == PH_TENTRY);
                           wr.idx = eidx_ff;
                           wr.data = shift_nx[CNT_W-1:0];
                           eidx_in = eidx_ff + 1'b1;
                           erem_in = erem_nx;
                           shift_in = '0;
                           if (erem_nx == '0) begin
                              if (phase_ff == PH_LENTRY) begin
                                 rem_in = COUNT_FIELD_BITS;
                                 phase_in = PH_TCOUNT;
                              end else begin
                                 phase_in = PH_CODE0;
                              end
                           end else begin
                              rem_in = ENTRY_FIELD_BITS;
                           end
                        end
                        PH_INDEX: begin
                           load_req = 1'b1;
                        end
                        PH_CENTER: begin
                           emit_req = 1'b1;
                           emit_val = prev_ff ^ (shift_nx << tz_ff);
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase

            if (load_req) begin
               c_lz = lead_data;
               c_tz = trail_data;
               lz_in = lead_data;
               tz_in = trail_data;
               center_req = 1'b1;
            end

            // A center width of zero or less yields the previous value at once.
            if (center_req) begin
               csum = {1'b0, c_lz} + {1'b0, c_tz};
               if (csum >= VALUE_BITS) begin
                  emit_req = 1'b1;
               end else begin
                  shift_in = '0;
                  rem_in = VALUE_BITS - csum;
                  phase_in = PH_CENTER;
               end
            end

            if (emit_req) begin
               res.valid = 1'b1;
               if (emit_val == terminator) begin
                  res.last = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  res.value = emit_val;
                  prev_in = emit_val;
                  phase_in = PH_CODE0;
               end
            end
         end
      end

      if (prev_load) begin
         prev_in = prev_load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         eq_ff <= 1'b0;
         lz_ff <= '0;
         tz_ff <= '0;
         liw_ff <= '0;
         tiw_ff <= '0;
         shift_ff <= '0;
         rem_ff <= '0;
         erem_ff <= '0;
         eidx_ff <= '0;
         prev_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         eq_ff <= eq_in;
         lz_ff <= lz_in;
         tz_ff <= tz_in;
         liw_ff <= liw_in;
         tiw_ff <= tiw_in;
         shift_ff <= shift_in;
         rem_ff <= rem_in;
         erem_ff <= erem_in;
         eidx_ff <= eidx_in;
         prev_ff <= prev_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/xor_float32_stream_decoder.sv
// Top level of the XOR float stream decoder: register port, decoder and result register.
// The decoder takes one compressed bit per cycle and updates its state on the
// cycle the bit is accepted; a value or block end appears in the result register
// on the next cycle. Sustained throughput is one bit per cycle, set by the single
// state update in the decode state machine. The input stalls only while the result
// register holds an item that the sink does not take. Register writes take effect
// on the cycle after they are accepted and are always accepted.
`default_nettype none

module xor_float32_stream_decoder #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [xfd_pkg::REQ_DATA_W-1:0]    req_tdata,  // [0] stream_bit, [7:1] zero
   input  wire                               req_tuser,  // [0] block_start
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [xfd_pkg::VALUE_W-1:0]       rsp_tdata,  // [31:0] decoded_value
   output logic                              rsp_tlast,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [xfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [xfd_pkg::VALUE_W-1:0]       csr_wdata
);
   import xfd_pkg::*;

   logic               accept;
   logic               prev_load;
   logic [VALUE_W-1:0] term_ff, term_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   tbl_rd_type         rd;
   tbl_wr_type         wr;
   res_type            res;
   logic [CNT_W-1:0]   lead_data;
   logic [CNT_W-1:0]   trail_data;

   assign csr_ready = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      term_in = term_ff;
      prev_load = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INIT_PREV: prev_load = 1'b1;
            CSR_TERMINATOR: term_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   xfd_tables #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_tables (
      .clock(clock),
      .reset(reset),
      .wr(wr),
      .rd(rd),
      .lead_data(lead_data),
      .trail_data(trail_data)
   );

   xfd_core u_core (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .bit_i(req_tdata[0]),
      .start_i(req_tuser),
      .prev_load(prev_load),
      .prev_load_val(csr_wdata),
      .terminator(term_ff),
      .lead_data(lead_data),
      .trail_data(trail_data),
      .rd(rd),
      .wr(wr),
      .res(res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = res.value;
         rsp_last_in = res.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= TERMINATOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         term_ff <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/xfd_checker.sv
// Port-level assertions for the XOR float stream decoder and their bind.
`default_nettype none

module xfd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled result changed.");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == 32'd0)
      else $error("Block end carries a nonzero value.");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("Input ready does not follow the result register.");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("Result appeared without an accepted item.");

endmodule

bind xor_float32_stream_decoder xfd_checker u_xfd_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the bit-serial XOR float stream decoder.
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      logic [31:0] value;
      logic        last;
   } dec_result_type;

   typedef struct packed {
      logic start;
      logic b;
   } stim_type;

   typedef logic [4:0] entry_q_type[$];

   typedef enum int {
      ST_IDLE, ST_FLAGS, ST_LCNT, ST_LENT, ST_TCNT, ST_TENT,
      ST_CODE0, ST_CODE1, ST_INDEX, ST_CENTER
   } dec_state_type;

   class decoder_mirror;
      logic [31:0] init_value;
      logic [31:0] stop_pattern;
      logic [31:0] last_value;
      bit          equal_window;
      int          lead_zeros;
      int          trail_zeros;
      logic [4:0]  lead_tab[16];
      logic [4:0]  trail_tab[16];
      int          lead_bits;
      int          trail_bits;
      dec_state_type state;
      logic [31:0] shreg;
      int          remaining;
      int          entries_left;
      int          entry_at;
      dec_result_type expected_values[$];
      int          made;
      int          errors;

      function new();
         init_value = '0;
         stop_pattern = xfd_pkg::TERMINATOR_RESET;
         last_value = '0;
         equal_window = 1'b0;
         lead_zeros = 0;
         trail_zeros = 0;
         foreach (lead_tab[i]) begin
            lead_tab[i] = '0;
            trail_tab[i] = '0;
         end
         lead_bits = 0;
         trail_bits = 0;
         state = ST_IDLE;
         shreg = '0;
         remaining = 0;
         entries_left = 0;
         entry_at = 0;
         made = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [xfd_pkg::CSR_IDX_W-1:0] idx, logic [31:0] v);
         if (idx == xfd_pkg::CSR_INIT_PREV) begin
            init_value = v;
            last_value = v;
         end else if (idx == xfd_pkg::CSR_TERMINATOR) begin
            stop_pattern = v;
         end
      endfunction

      function int bits_for(int n);
         int w;
         w = 0;
         while (w < 4 && (1 << w) < n) w++;
         return w;
      endfunction

      function void emit(logic [31:0] v);
         if (v == stop_pattern) begin
            expected_values.push_back('{value: 32'd0, last: 1'b1});
            state = ST_IDLE;
         end else begin
            expected_values.push_back('{value: v, last: 1'b0});
            last_value = v;
            state = ST_CODE0;
         end
         made++;
      endfunction

      function void open_field(dec_state_type st, int n);
         shreg = '0;
         remaining = n;
         state = st;
      endfunction

      function void start_center();
         int n;
         n = 32 - lead_zeros - trail_zeros;
         if (n <= 0) emit(last_value);
         else open_field(ST_CENTER, n);
      endfunction

      function void load_indices(logic [7:0] v);
         int li;
         int ti;
         li = int'(v) >> trail_bits;
         ti = int'(v) & ((1 << trail_bits) - 1);
         lead_zeros = (li < 16) ? int'(lead_tab[li]) : 0;
         trail_zeros = (ti < 16) ? int'(trail_tab[ti]) : 0;
         start_center();
      endfunction

      function void new_indices();
         if (lead_bits + trail_bits == 0) load_indices(8'd0);
         else open_field(ST_INDEX, lead_bits + trail_bits);
      endfunction

      function void open_table(logic [3:0] c, bit lead);
         int n;
         n = (c == 4'd0) ? 16 : int'(c);
         if (lead) lead_bits = bits_for(n);
         else trail_bits = bits_for(n);
         entries_left = n;
         entry_at = 0;
         open_field(lead ? ST_LENT : ST_TENT, 5);
      endfunction

      function void accept_bit(logic b, logic start);
         bit lead;
         if (start) begin
            equal_window = b;
            state = ST_FLAGS;
            return;
         end
         case (state)
            ST_IDLE: return;
            ST_FLAGS: begin
               if (b) open_field(ST_LCNT, 4);
               else state = ST_CODE0;
               return;
            end
            ST_CODE0: begin
               if (!b) state = ST_CODE1;
               else if (equal_window) emit(last_value);
               else start_center();
               return;
            end
            ST_CODE1: begin
               if (!b) new_indices();
               else if (equal_window) start_center();
               else emit(last_value);
               return;
            end
            default: ;
         endcase
         shreg = {shreg[30:0], b};
         if (remaining > 0) remaining--;
         if (remaining != 0) return;
         case (state)
            ST_LCNT: open_table(shreg[3:0], 1'b1);
            ST_TCNT: open_table(shreg[3:0], 1'b0);
            ST_LENT, ST_TENT: begin
               lead = (state == ST_LENT);
               if (entry_at < 16) begin
                  if (lead) lead_tab[entry_at] = shreg[4:0];
                  else trail_tab[entry_at] = shreg[4:0];
               end
               entry_at = (entry_at + 1) & 31;
               if (entries_left > 0) entries_left--;
               if (entries_left != 0) open_field(state, 5);
               else if (lead) open_field(ST_TCNT, 4);
               else state = ST_CODE0;
            end
            ST_INDEX: load_indices(shreg[7:0]);
            ST_CENTER: emit(last_value ^ (shreg << trail_zeros));
            default: ;
         endcase
      endfunction

      function void compare_value(logic [31:0] v, logic l);
         dec_result_type want;
         if (expected_values.size() == 0) begin
            $error("unexpected item: decoded_value %h, block_end %b", v, l);
            errors++;
            return;
         end
         want = expected_values.pop_front();
         if (l !== want.last) begin
            $error("block_end: expected %b, actual %b", want.last, l);
            errors++;
         end
         if (v !== want.value) begin
            $error("decoded_value: expected %h, actual %h", want.value, v);
            errors++;
         end
      endfunction

      function int pending();
         return expected_values.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [xfd_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [xfd_pkg::VALUE_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [xfd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [xfd_pkg::VALUE_W-1:0] csr_wdata = '0;

   decoder_mirror mirror;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int sent_bits = 0;
   stim_type stim_q[$];

   // Encoder-side copy of the decoder state, used to aim codes at the terminator.
   logic [31:0] g_prev;
   logic [31:0] g_term;
   int          g_lead;
   int          g_trail;
   logic [4:0]  g_ltab[16];
   logic [4:0]  g_ttab[16];
   int          g_lw;
   int          g_tw;
   bit          g_ew;
   bit          g_done;

   xor_float32_stream_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mirror.compare_value(rsp_tdata, rsp_tlast);
      end
   end

   function automatic void sync_encoder();
      g_prev = mirror.last_value;
      g_term = mirror.stop_pattern;
      g_lead = mirror.lead_zeros;
      g_trail = mirror.trail_zeros;
      g_ltab = mirror.lead_tab;
      g_ttab = mirror.trail_tab;
      g_lw = mirror.lead_bits;
      g_tw = mirror.trail_bits;
      g_done = 1'b0;
   endfunction

   function automatic void put_bits(logic [31:0] v, int n);
      for (int i = n - 1; i >= 0; i--) begin
         stim_q.push_back('{start: 1'b0, b: v[i]});
      end
   endfunction

   function automatic void put_start(bit ew);
      stim_q.push_back('{start: 1'b1, b: ew});
      g_ew = ew;
      g_done = 1'b0;
   endfunction

   function automatic void put_table(bit lead, entry_q_type ents);
      int n;
      int w;
      n = ents.size();
      w = 0;
      while (w < 4 && (1 << w) < n) w++;
      put_bits(32'(n & 15), 4);
      foreach (ents[i]) begin
         put_bits(32'(ents[i]), 5);
         if (lead) g_ltab[i] = ents[i];
         else g_ttab[i] = ents[i];
      end
      if (lead) g_lw = w;
      else g_tw = w;
   endfunction

   function automatic void put_random_table(bit lead);
      entry_q_type ents;
      int r;
      int n;
      r = $urandom_range(9);
      n = (r == 0) ? 16 : (r == 1) ? $urandom_range(6, 15) : $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
         ents.push_back(5'($urandom_range(1) ? $urandom_range(31) : $urandom_range(12)));
      end
      if ($urandom_range(9) < 8) ents[0] = 5'd0;
      put_table(lead, ents);
   endfunction

   function automatic void deliver(logic [31:0] v);
      if (v == g_term) g_done = 1'b1;
      else g_prev = v;
   endfunction

   function automatic void put_center(logic [31:0] c);
      int n;
      logic [31:0] m;
      n = 32 - g_lead - g_trail;
      if (n <= 0) begin
         deliver(g_prev);
         return;
      end
      m = (n == 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
      put_bits(c, n);
      deliver(g_prev ^ ((c & m) << g_trail));
   endfunction

   function automatic void put_repeat();
      put_bits(32'd1, g_ew ? 1 : 2);
      deliver(g_prev);
   endfunction

   function automatic void put_reuse(logic [31:0] c);
      put_bits(32'd1, g_ew ? 2 : 1);
      put_center(c);
   endfunction

   function automatic void put_new(int li, int ti, logic [31:0] c);
      int l;
      int t;
      l = li & ((1 << g_lw) - 1);
      t = ti & ((1 << g_tw) - 1);
      put_bits(32'd0, 2);
      put_bits((l << g_tw) | t, g_lw + g_tw);
      g_lead = int'(g_ltab[l]);
      g_trail = int'(g_ttab[t]);
      put_center(c);
   endfunction

   function automatic bit fits(int L, int T, logic [31:0] d);
      if (32 - L - T <= 0) return d == 32'd0;
      return (((d >> T) << T) == d) && ((d >> (32 - L)) == 32'd0);
   endfunction

   function automatic bit put_terminator();
      logic [31:0] d;
      d = g_prev ^ g_term;
      if (d == 32'd0) begin
         put_repeat();
         return 1'b1;
      end
      if ($urandom_range(1) && fits(g_lead, g_trail, d)) begin
         put_reuse(d >> g_trail);
         return 1'b1;
      end
      for (int li = 0; li < (1 << g_lw); li++) begin
         for (int ti = 0; ti < (1 << g_tw); ti++) begin
            if (fits(int'(g_ltab[li]), int'(g_ttab[ti]), d)) begin
               put_new(li, ti, d >> g_ttab[ti]);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic void put_block();
      int k;
      int f;
      put_start(1'($urandom_range(1)));
      if ($urandom_range(3) != 0) begin
         put_bits(32'd1, 1);
         put_random_table(1'b1);
         put_random_table(1'b0);
      end else begin
         put_bits(32'd0, 1);
      end
      k = $urandom_range(1, 6);
      for (int i = 0; i < k && !g_done; i++) begin
         f = $urandom_range(9);
         if (f < 3) put_repeat();
         else if (f < 6) put_reuse($urandom());
         else put_new($urandom_range(15), $urandom_range(15), $urandom());
      end
      if (!g_done && $urandom_range(9) != 0) void'(put_terminator());
      put_bits($urandom(), $urandom_range(0, 3));
   endfunction

   function automatic void build_block();
      int kind;
      int cut;
      sync_encoder();
      kind = $urandom_range(99);
      if (kind < 90) begin
         put_block();
         // A cut-off block is followed by whatever stimulus is built next.
         if (kind >= 75 && stim_q.size() > 2) begin
            cut = $urandom_range(1, stim_q.size() - 1);
            stim_q = stim_q[0:cut-1];
         end
      end else begin
         for (int i = $urandom_range(4, 20); i > 0; i--) begin
            stim_q.push_back('{start: ($urandom_range(7) == 0), b: 1'($urandom_range(1))});
         end
      end
   endfunction

   task automatic send_bit(stim_type s);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(xfd_pkg::REQ_DATA_W-1){1'b0}}, s.b};
      req_tuser <= s.start;
      do @(posedge clock); while (!req_tready);
      mirror.accept_bit(s.b, s.start);
      sent_bits++;
   endtask

   task automatic send_all();
      while (stim_q.size() != 0) send_bit(stim_q.pop_front());
   endtask

   task automatic csr_write(logic [xfd_pkg::CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      mirror.write_reg(idx, v);
   endtask

   task automatic set_regs(logic [31:0] init_prev, logic [31:0] stop);
      csr_write(xfd_pkg::CSR_INIT_PREV, init_prev);
      csr_write(xfd_pkg::CSR_TERMINATOR, stop);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_random(int min_bits, int min_results);
      int bits0;
      int made0;
      bits0 = sent_bits;
      made0 = mirror.made;
      while (sent_bits - bits0 < min_bits || mirror.made - made0 < min_results) begin
         build_block();
         send_all();
      end
   endtask

   task automatic run_directed();
      sync_encoder();
      // Bits before any block start are ignored.
      put_bits(32'd2, 2);
      // Repeat, then new indices with zero-width index fields reaching the terminator.
      put_start(1'b1);
      put_bits(32'd0, 1);
      put_repeat();
      put_new(0, 0, g_prev ^ g_term);
      put_bits(32'd1, 1);
      // Tables whose counts add past 32 clamp the center width to zero.
      put_start(1'b0);
      put_bits(32'd1, 1);
      put_table(1'b1, {5'd31});
      put_table(1'b0, {5'd31});
      put_new(0, 0, 32'd0);
      put_reuse(32'd0);
      put_repeat();
      // A new header aborts the previous block; this one is cut in its center bits.
      put_start(1'b1);
      put_bits(32'd1, 1);
      put_table(1'b1, {5'd0, 5'd3});
      put_table(1'b0, {5'd0, 5'd1, 5'd31});
      put_bits(32'd0, 2);
      put_bits(32'd5, 3);
      put_bits(32'h15, 5);
      // Header without update keeps the tables; index 3 lies past the trail count.
      put_start(1'b1);
      put_bits(32'd0, 1);
      put_new(1, 3, 32'hFFFF_FFFF);
      void'(put_terminator());
      send_all();
   endtask

   initial begin
      mirror = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_regs(32'd0, xfd_pkg::TERMINATOR_RESET);
      run_directed();
      settle();

      tx_idle_pct = 7;
      rx_idle_pct = 84;
      set_regs($urandom(), $urandom());
      run_random(320, 16);
      settle();

      tx_idle_pct = 84;
      rx_idle_pct = 7;
      set_regs(32'hFFFF_FFFF, 32'd0);
      run_random(320, 16);
      settle();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_regs(32'd0, 32'hFFFF_FFFF);
      run_random(320, 16);
      settle();

      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("** xor_float32_stream_decoder: PASSED **");
      end else begin
         $display("** xor_float32_stream_decoder: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** xor_float32_stream_decoder: FAILED **");
      $finish;
   end

endmodule
